### src/knnt_pkg.sv
// knnt_pkg: shared types and constants for the k-nearest list with ties
// no dependencies; imported by knnt_cell, knnt_chain and the top level
package knnt_pkg;

  // fixed field widths
  localparam int DIST_W  = 32;
  localparam int K_W     = 6;
  localparam int COUNT_W = 6;
  localparam int OP_W    = 2;

  // apb port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register select on paddr[2]
  localparam logic REG_NEIGHBOURS_K = 1'b0;
  localparam logic [K_W-1:0] K_RESET = 6'd3;

  // parameter defaults
  localparam int CAPACITY_DEF = 32;
  localparam int ID_WIDTH_DEF = 16;

  // input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_OFFER  = 2'd1,
    OP_DUMP   = 2'd2,
    OP_STATUS = 2'd3
  } op_e;

  // command broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     drop;
  } cell_ctl_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

endpackage

### src/knnt_cell.sv
// knnt_cell: one slot of the sorted candidate row (id and distance)
// depends on knnt_pkg; instantiated by knnt_chain
module knnt_cell #(
  parameter int CAPACITY = 32,
  parameter int ID_WIDTH = 16,
  parameter int IDX      = 0
) (
  input  logic                             clk_i,
  input  knnt_pkg::cell_ctl_t              ctl_i,
  input  logic [$clog2(CAPACITY+1)-1:0]    total_i,
  input  logic [knnt_pkg::DIST_W-1:0]      cur_max_i,
  input  logic [ID_WIDTH-1:0]              new_id_i,
  input  logic [knnt_pkg::DIST_W-1:0]      new_dist_i,
  input  logic                             prev_ins_i,
  input  logic [ID_WIDTH-1:0]              prev_id_i,
  input  logic [knnt_pkg::DIST_W-1:0]      prev_dist_i,
  input  logic [ID_WIDTH-1:0]              next_id_i,
  input  logic [knnt_pkg::DIST_W-1:0]      next_dist_i,
  input  logic [ID_WIDTH-1:0]              head_id_i,
  input  logic [knnt_pkg::DIST_W-1:0]      head_dist_i,
  output logic                             ins_o,
  output logic                             lt_o,
  output logic [ID_WIDTH-1:0]              id_o,
  output logic [knnt_pkg::DIST_W-1:0]      dist_o
);
  import knnt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] LAST_C = CNT_W'(IDX + 1);

  logic [ID_WIDTH-1:0] id_q, id_d;
  logic [DIST_W-1:0]   dist_q, dist_d;
  logic                slot_valid;
  logic                keep_valid;

  // slot flags: held, strictly below the bound, insert point at or before
  always_comb begin
    slot_valid = IDX_C < total_i;
    lt_o       = slot_valid && (dist_q < cur_max_i);
    keep_valid = ctl_i.drop ? lt_o : slot_valid;
    ins_o      = !keep_valid || (new_dist_i < dist_q);
  end

  // next slot contents
  always_comb begin
    id_d   = id_q;
    dist_d = dist_q;
    unique case (ctl_i.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (prev_ins_i) begin
          id_d   = prev_id_i;
          dist_d = prev_dist_i;
        end else if (ins_o) begin
          id_d   = new_id_i;
          dist_d = new_dist_i;
        end
      end
      CELL_ROTATE: begin
        if (LAST_C == total_i) begin
          id_d   = head_id_i;
          dist_d = head_dist_i;
        end else begin
          id_d   = next_id_i;
          dist_d = next_dist_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    dist_q <= dist_d;
  end

  assign id_o   = id_q;
  assign dist_o = dist_q;

endmodule

### src/knnt_chain.sv
// knnt_chain: row of knnt_cell slots kept in rising distance order
// depends on knnt_pkg and knnt_cell; reports the count below the bound
module knnt_chain #(
  parameter int CAPACITY = 32,
  parameter int ID_WIDTH = 16
) (
  input  logic                             clk_i,
  input  knnt_pkg::cell_ctl_t              ctl_i,
  input  logic [$clog2(CAPACITY+1)-1:0]    total_i,
  input  logic [knnt_pkg::DIST_W-1:0]      cur_max_i,
  input  logic [ID_WIDTH-1:0]              new_id_i,
  input  logic [knnt_pkg::DIST_W-1:0]      new_dist_i,
  output logic [$clog2(CAPACITY+1)-1:0]    keep_o,
  output logic [knnt_pkg::DIST_W-1:0]      bnd_dist_o,
  output logic [ID_WIDTH-1:0]              head_id_o,
  output logic [knnt_pkg::DIST_W-1:0]      head_dist_o
);
  import knnt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [ID_WIDTH-1:0] ids   [CAPACITY];
  logic [DIST_W-1:0]   dists [CAPACITY];
  logic [CAPACITY-1:0] ins_w;
  logic [CAPACITY:0]   lt_w;
  logic [CAPACITY-1:0] bnd_w;

  assign lt_w[CAPACITY] = 1'b0;

  // the cell row; each cell sees its left and right neighbor and the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                prev_ins;
    logic [ID_WIDTH-1:0] prev_id;
    logic [DIST_W-1:0]   prev_dist;
    logic [ID_WIDTH-1:0] next_id;
    logic [DIST_W-1:0]   next_dist;

    if (i == 0) begin : g_first
      assign prev_ins  = 1'b0;
      assign prev_id   = '0;
      assign prev_dist = '0;
    end else begin : g_inner
      assign prev_ins  = ins_w[i-1];
      assign prev_id   = ids[i-1];
      assign prev_dist = dists[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign next_id   = ids[0];
      assign next_dist = dists[0];
    end else begin : g_mid
      assign next_id   = ids[i+1];
      assign next_dist = dists[i+1];
    end

    knnt_cell #(
      .CAPACITY (CAPACITY),
      .ID_WIDTH (ID_WIDTH),
      .IDX      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl_i),
      .total_i     (total_i),
      .cur_max_i   (cur_max_i),
      .new_id_i    (new_id_i),
      .new_dist_i  (new_dist_i),
      .prev_ins_i  (prev_ins),
      .prev_id_i   (prev_id),
      .prev_dist_i (prev_dist),
      .next_id_i   (next_id),
      .next_dist_i (next_dist),
      .head_id_i   (ids[0]),
      .head_dist_i (dists[0]),
      .ins_o       (ins_w[i]),
      .lt_o        (lt_w[i]),
      .id_o        (ids[i]),
      .dist_o      (dists[i])
    );
  end

  // below-bound flags form a thermometer; its edge gives count and last distance
  always_comb begin
    keep_o     = '0;
    bnd_dist_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      bnd_w[i] = lt_w[i] && !lt_w[i+1];
      if (bnd_w[i]) begin
        keep_o     = keep_o | CNT_W'(i + 1);
        bnd_dist_o = bnd_dist_o | dists[i];
      end
    end
  end

  assign head_id_o   = ids[0];
  assign head_dist_o = dists[0];

endmodule

### src/k_nearest_with_ties_list_top.sv
// k_nearest_with_ties_list_top: sorted nearest-candidate list with ties
// clear, offer and status: result registered in the cycle after the transfer, one item per
// cycle while results are taken; dump: after the state moves to dump, one entry per cycle
// while results are taken, from the head of the cell row, which rotates once per entry
// the next item is taken after the last result of the previous one has left or is leaving
// reset empties the list, clears the bound and sets k to 3; held slots are not cleared
// depends on knnt_pkg and knnt_chain
module k_nearest_with_ties_list_top #(
  parameter int CAPACITY = knnt_pkg::CAPACITY_DEF,
  parameter int ID_WIDTH = knnt_pkg::ID_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // apb configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [knnt_pkg::PADDR_W-1:0]     paddr,
  input  logic [knnt_pkg::PDATA_W-1:0]     pwdata,
  output logic [knnt_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [knnt_pkg::OP_W-1:0]        operation_i,
  input  logic [ID_WIDTH-1:0]              item_id_i,
  input  logic [knnt_pkg::DIST_W-1:0]      distance_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             entry_valid_o,
  output logic [ID_WIDTH-1:0]              entry_id_o,
  output logic [knnt_pkg::DIST_W-1:0]      entry_distance_o,
  output logic [knnt_pkg::COUNT_W-1:0]     held_count_o,
  output logic [knnt_pkg::DIST_W-1:0]      max_distance_o,
  output logic                             accepted_o,
  output logic                             overflow_o,
  output logic                             last_o
);
  import knnt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > K_W) ? CNT_W : K_W) + 1;

  state_e              state_q, state_d;
  logic [K_W-1:0]      k_q;
  logic [CNT_W-1:0]    total_q, total_d;
  logic [DIST_W-1:0]   max_q, max_d;
  logic [CNT_W-1:0]    dump_idx_q, dump_idx_d;

  logic                out_valid_q, out_valid_d;
  logic                o_entry_valid_q, o_entry_valid_d;
  logic [ID_WIDTH-1:0] o_id_q, o_id_d;
  logic [DIST_W-1:0]   o_dist_q, o_dist_d;
  logic [CNT_W-1:0]    o_count_q, o_count_d;
  logic [DIST_W-1:0]   o_max_q, o_max_d;
  logic                o_acc_q, o_acc_d;
  logic                o_ovf_q, o_ovf_d;
  logic                o_last_q, o_last_d;

  cell_ctl_t           ctl;
  logic [CNT_W-1:0]    keep;
  logic [DIST_W-1:0]   bnd_dist;
  logic [ID_WIDTH-1:0] head_id;
  logic [DIST_W-1:0]   head_dist;

  op_e                 op;
  logic                in_xfer;
  logic                out_free;
  logic                cfg_wr;
  logic                dump_last;
  logic [K_W-1:0]      k_eff;
  logic                full;
  logic                fill;
  logic                drop_ok;
  logic                off_ins;
  logic                off_drop;
  logic                off_ovf;
  logic [CNT_W-1:0]    off_total;
  logic [DIST_W-1:0]   off_max;

  // apb: single register, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NEIGHBOURS_K);
  assign prdata = (paddr[2] == REG_NEIGHBOURS_K) ? PDATA_W'(k_q) : '0;

  // handshake
  assign op         = op_e'(operation_i);
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign dump_last  = dump_idx_q == (total_q - CNT_W'(1));

  // offer decision
  always_comb begin
    k_eff     = (k_q == '0) ? K_W'(1) : k_q;
    full      = total_q == CNT_W'(CAPACITY);
    fill      = CMP_W'(total_q) < CMP_W'(k_eff);
    drop_ok   = (CMP_W'(keep) + CMP_W'(1)) >= CMP_W'(k_eff);
    off_ins   = 1'b0;
    off_drop  = 1'b0;
    off_ovf   = 1'b0;
    off_total = total_q;
    off_max   = max_q;
    if (fill || (distance_i == max_q) || ((distance_i < max_q) && !drop_ok)) begin
      if (full) begin
        off_ovf = 1'b1;
      end else begin
        off_ins   = 1'b1;
        off_total = total_q + CNT_W'(1);
        if (fill && ((total_q == '0) || (distance_i > max_q))) begin
          off_max = distance_i;
        end
      end
    end else if (distance_i < max_q) begin
      off_ins   = 1'b1;
      off_drop  = 1'b1;
      off_total = keep + CNT_W'(1);
      off_max   = ((keep == '0) || (distance_i > bnd_dist)) ? distance_i : bnd_dist;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (op == OP_DUMP) && (total_q != '0)) begin
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (out_free && dump_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control and result register loads
  always_comb begin
    ctl             = '{op: CELL_HOLD, drop: 1'b0};
    total_d         = total_q;
    max_d           = max_q;
    dump_idx_d      = dump_idx_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    o_entry_valid_d = o_entry_valid_q;
    o_id_d          = o_id_q;
    o_dist_d        = o_dist_q;
    o_count_d       = o_count_q;
    o_max_d         = o_max_q;
    o_acc_d         = o_acc_q;
    o_ovf_d         = o_ovf_q;
    o_last_d        = o_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          // status result shared by every non-dump transfer and by a dump of an empty list
          o_entry_valid_d = 1'b0;
          o_id_d          = '0;
          o_dist_d        = '0;
          o_count_d       = total_q;
          o_max_d         = max_q;
          o_acc_d         = 1'b0;
          o_ovf_d         = 1'b0;
          o_last_d        = 1'b1;
          out_valid_d     = 1'b1;
          unique case (op)
            OP_CLEAR: begin
              total_d   = '0;
              max_d     = '0;
              o_count_d = '0;
              o_max_d   = '0;
            end
            OP_OFFER: begin
              if (off_ins) begin
                ctl     = '{op: CELL_INSERT, drop: off_drop};
                total_d = off_total;
                max_d   = off_max;
              end
              o_count_d = off_total;
              o_max_d   = off_max;
              o_acc_d   = off_ins;
              o_ovf_d   = off_ovf;
            end
            OP_DUMP: begin
              if (total_q != '0) begin
                out_valid_d = out_valid_q && !out_ready_i;
                dump_idx_d  = '0;
              end
            end
            OP_STATUS: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_DUMP: begin
        // head entry goes out, the row rotates by one
        if (out_free) begin
          ctl             = '{op: CELL_ROTATE, drop: 1'b0};
          dump_idx_d      = dump_idx_q + CNT_W'(1);
          out_valid_d     = 1'b1;
          o_entry_valid_d = 1'b1;
          o_id_d          = head_id;
          o_dist_d        = head_dist;
          o_count_d       = total_q;
          o_max_d         = max_q;
          o_acc_d         = 1'b0;
          o_ovf_d         = 1'b0;
          o_last_d        = dump_last;
        end
      end
      default: begin
      end
    endcase
  end

  knnt_chain #(
    .CAPACITY (CAPACITY),
    .ID_WIDTH (ID_WIDTH)
  ) u_chain (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .total_i     (total_q),
    .cur_max_i   (max_q),
    .new_id_i    (item_id_i),
    .new_dist_i  (distance_i),
    .keep_o      (keep),
    .bnd_dist_o  (bnd_dist),
    .head_id_o   (head_id),
    .head_dist_o (head_dist)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= K_RESET;
      total_q     <= '0;
      max_q       <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      max_q       <= max_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        k_q <= pwdata[K_W-1:0];
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    o_entry_valid_q <= o_entry_valid_d;
    o_id_q          <= o_id_d;
    o_dist_q        <= o_dist_d;
    o_count_q       <= o_count_d;
    o_max_q         <= o_max_d;
    o_acc_q         <= o_acc_d;
    o_ovf_q         <= o_ovf_d;
    o_last_q        <= o_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign entry_valid_o    = o_entry_valid_q;
  assign entry_id_o       = o_id_q;
  assign entry_distance_o = o_dist_q;
  assign held_count_o     = COUNT_W'(o_count_q);
  assign max_distance_o   = o_max_q;
  assign accepted_o       = o_acc_q;
  assign overflow_o       = o_ovf_q;
  assign last_o           = o_last_q;

endmodule

### verif/knnt_list_checker.sv
// knnt_list_checker: predicts and checks every result of the k-nearest list with ties
// watches the apb write, input and output channels; depends on knnt_pkg only
module knnt_list_checker #(
  parameter int CAPACITY = knnt_pkg::CAPACITY_DEF,
  parameter int ID_WIDTH = knnt_pkg::ID_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb write observation
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [knnt_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [knnt_pkg::PDATA_W-1:0]  pwdata_i,
  // input channel
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [knnt_pkg::OP_W-1:0]     operation_i,
  input  logic [ID_WIDTH-1:0]           item_id_i,
  input  logic [knnt_pkg::DIST_W-1:0]   distance_i,
  // output channel
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          entry_valid_i,
  input  logic [ID_WIDTH-1:0]           entry_id_i,
  input  logic [knnt_pkg::DIST_W-1:0]   entry_distance_i,
  input  logic [knnt_pkg::COUNT_W-1:0]  held_count_i,
  input  logic [knnt_pkg::DIST_W-1:0]   max_distance_i,
  input  logic                          accepted_i,
  input  logic                          overflow_i,
  input  logic                          last_i,
  // verdict
  output int                            fail_count_o,
  output int                            pending_o
);
  import knnt_pkg::*;

  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic                entry_valid;
    logic [ID_WIDTH-1:0] entry_id;
    logic [DIST_W-1:0]   entry_distance;
    logic [COUNT_W-1:0]  held_count;
    logic [DIST_W-1:0]   max_distance;
    logic                accepted;
    logic                overflow;
    logic                last;
  } knn_result_t;

  // predicted list state
  logic [ID_WIDTH-1:0] held_id   [CAPACITY];
  logic [DIST_W-1:0]   held_dist [CAPACITY];
  int                  held_total = 0;
  logic [DIST_W-1:0]   bound      = '0;
  logic [K_W-1:0]      k_reg      = K_RESET;

  knn_result_t expected_results_q[$];
  knn_result_t front;
  int          fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // queue one result with the current count and bound
  function automatic void push_result(input logic ev, input logic [ID_WIDTH-1:0] id,
                                      input logic [DIST_W-1:0] d, input logic acc,
                                      input logic ovf, input logic fin);
    knn_result_t r;
    r.entry_valid    = ev;
    r.entry_id       = id;
    r.entry_distance = d;
    r.held_count     = COUNT_W'(held_total);
    r.max_distance   = bound;
    r.accepted       = acc;
    r.overflow       = ovf;
    r.last           = fin;
    expected_results_q.push_back(r);
  endfunction

  // place after every entry of equal or smaller distance
  function automatic void insert_sorted(input logic [ID_WIDTH-1:0] id,
                                        input logic [DIST_W-1:0] d);
    int m;
    m = held_total;
    while (m > 0 && d < held_dist[m-1]) begin
      held_id[m]   = held_id[m-1];
      held_dist[m] = held_dist[m-1];
      m--;
    end
    held_id[m]   = id;
    held_dist[m] = d;
    held_total++;
  endfunction

  // list update and expected results for one input transfer
  function automatic void predict_item(input logic [OP_W-1:0] op,
                                       input logic [ID_WIDTH-1:0] id,
                                       input logic [DIST_W-1:0] d);
    int   k;
    int   keep;
    logic acc;
    logic ovf;
    k   = (k_reg == '0) ? 1 : int'(k_reg);
    acc = 1'b0;
    ovf = 1'b0;
    case (op)
      OP_CLEAR: begin
        held_total = 0;
        bound      = '0;
        push_result(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
      end
      OP_DUMP: begin
        if (held_total == 0) begin
          push_result(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < held_total; i++)
            push_result(1'b1, held_id[i], held_dist[i], 1'b0, 1'b0, i == held_total - 1);
        end
      end
      OP_STATUS: begin
        push_result(1'b0, '0, '0, 1'b0, 1'b0, 1'b1);
      end
      default: begin
        if (held_total < k) begin
          // still filling up to k entries
          if (held_total >= CAPACITY) begin
            ovf = 1'b1;
          end else begin
            insert_sorted(id, d);
            bound = held_dist[held_total-1];
            acc   = 1'b1;
          end
        end else if (d < bound) begin
          // count entries strictly below the bound
          keep = held_total - 1;
          while (keep > 0 && held_dist[keep-1] == bound) keep--;
          if (keep < k - 1) begin
            if (held_total >= CAPACITY) begin
              ovf = 1'b1;
            end else begin
              insert_sorted(id, d);
              acc = 1'b1;
            end
          end else begin
            // drop the ties at the bound, then insert
            held_total = keep;
            insert_sorted(id, d);
            bound = held_dist[held_total-1];
            acc   = 1'b1;
          end
        end else if (d == bound) begin
          // tie with the bound is appended
          if (held_total >= CAPACITY) begin
            ovf = 1'b1;
          end else begin
            held_id[held_total]   = id;
            held_dist[held_total] = d;
            held_total++;
            acc = 1'b1;
          end
        end
        push_result(1'b0, '0, '0, acc, ovf, 1'b1);
      end
    endcase
  endfunction

  // compare one field and report a mismatch
  function automatic void check_field(input string name, input logic [DIST_W-1:0] exp_v,
                                      input logic [DIST_W-1:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // watch config writes, result transfers and input transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_total = 0;
      bound      = '0;
      k_reg      = K_RESET;
      expected_results_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == REG_NEIGHBOURS_K)
        k_reg = pwdata_i[K_W-1:0];
      if (out_valid_i && out_ready_i) begin
        if (expected_results_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: result transfer with nothing expected, held_count %0d last %0b",
                     $time, held_count_i, last_i);
        end else begin
          front = expected_results_q.pop_front();
          check_field("entry_valid", DIST_W'(front.entry_valid), DIST_W'(entry_valid_i));
          check_field("entry_id", DIST_W'(front.entry_id), DIST_W'(entry_id_i));
          check_field("entry_distance", front.entry_distance, entry_distance_i);
          check_field("held_count", DIST_W'(front.held_count), DIST_W'(held_count_i));
          check_field("max_distance", front.max_distance, max_distance_i);
          check_field("accepted", DIST_W'(front.accepted), DIST_W'(accepted_i));
          check_field("overflow", DIST_W'(front.overflow), DIST_W'(overflow_i));
          check_field("last", DIST_W'(front.last), DIST_W'(last_i));
        end
      end
      if (in_valid_i && in_ready_i)
        predict_item(operation_i, item_id_i, distance_i);
    end
    fail_count_o <= fails;
    pending_o    <= expected_results_q.size();
  end

endmodule

### verif/tb_k_nearest_with_ties_list_top.sv
// tb_k_nearest_with_ties_list_top: stimulus, idling and verdict for the k-nearest list
// depends on knnt_pkg, k_nearest_with_ties_list_top and knnt_list_checker
module tb_k_nearest_with_ties_list_top;
  import knnt_pkg::*;

  localparam int ID_W = ID_WIDTH_DEF;

  // clock, reset and block inputs, all known from time zero
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr      = '0;
  logic [PDATA_W-1:0] pwdata     = '0;
  logic              in_valid_i  = 1'b0;
  logic [OP_W-1:0]   operation_i = '0;
  logic [ID_W-1:0]   item_id_i   = '0;
  logic [DIST_W-1:0] distance_i  = '0;
  logic              out_ready_i = 1'b0;

  logic [PDATA_W-1:0] prdata;
  logic              pready;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              entry_valid_o;
  logic [ID_W-1:0]   entry_id_o;
  logic [DIST_W-1:0] entry_distance_o;
  logic [COUNT_W-1:0] held_count_o;
  logic [DIST_W-1:0] max_distance_o;
  logic              accepted_o;
  logic              overflow_o;
  logic              last_o;

  int fail_count;
  int pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int k_list[6]   = '{1, 32, 0, 63, 2, 9};

  k_nearest_with_ties_list_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .item_id_i       (item_id_i),
    .distance_i      (distance_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .entry_valid_o   (entry_valid_o),
    .entry_id_o      (entry_id_o),
    .entry_distance_o(entry_distance_o),
    .held_count_o    (held_count_o),
    .max_distance_o  (max_distance_o),
    .accepted_o      (accepted_o),
    .overflow_o      (overflow_o),
    .last_o          (last_o)
  );

  knnt_list_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .operation_i     (operation_i),
    .item_id_i       (item_id_i),
    .distance_i      (distance_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .entry_valid_i   (entry_valid_o),
    .entry_id_i      (entry_id_o),
    .entry_distance_i(entry_distance_o),
    .held_count_i    (held_count_o),
    .max_distance_i  (max_distance_o),
    .accepted_i      (accepted_o),
    .overflow_i      (overflow_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // hard limit on the run
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // one input transfer, with a random gap in front of it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [DIST_W-1:0] dist_v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    item_id_i   <= id;
    distance_i  <= dist_v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // apb write of k, setup then access; upper data bits are junk
  task automatic write_k(input logic [K_W-1:0] k_val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_NEIGHBOURS_K, 2'b00};
    pwdata  <= {(PDATA_W-K_W)'($urandom), k_val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // distances clustered around a base so that ties are common
  function automatic logic [DIST_W-1:0] pick_distance(input logic [DIST_W-1:0] base,
                                                      input int spread);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return DIST_W'($urandom);
    return base + DIST_W'($urandom_range(0, spread));
  endfunction

  // mostly clear, offer burst, dump sequences; some random noise items
  task automatic run_phase(input int n_items, input int k_now);
    int               sent;
    int               k_eff;
    int               n_offers;
    int               spread;
    logic [DIST_W-1:0] base;
    sent  = 0;
    k_eff = (k_now == 0) ? 1 : k_now;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0) begin
          send_item(OP_CLEAR, ID_W'($urandom), DIST_W'($urandom));
          sent++;
        end
        n_offers = $urandom_range(1, (k_eff >= 32) ? 40 : 3 * k_eff + 4);
        case ($urandom_range(0, 3))
          0:       spread = 0;
          1:       spread = 3;
          2:       spread = 15;
          default: spread = 1000;
        endcase
        base = DIST_W'($urandom);
        repeat (n_offers) begin
          send_item(OP_OFFER, ID_W'($urandom), pick_distance(base, spread));
          sent++;
          if ($urandom_range(0, 11) == 0) begin
            send_item(OP_DUMP, ID_W'($urandom), DIST_W'($urandom));
            sent++;
          end
        end
        send_item(OP_DUMP, ID_W'($urandom), DIST_W'($urandom));
        sent++;
      end else begin
        send_item(OP_W'($urandom_range(0, 3)), ID_W'($urandom), DIST_W'($urandom));
        sent++;
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 23;
    rx_idle_pct = 79;

    // reset k of three: empty dump, status, extremes, ties, drop of ties, ignore
    send_item(OP_DUMP, '0, '0);
    send_item(OP_STATUS, '1, '1);
    send_item(OP_OFFER, '0, '0);
    send_item(OP_OFFER, '1, '1);
    send_item(OP_OFFER, 16'h1234, 32'd100);
    send_item(OP_OFFER, 16'h5555, '1);
    send_item(OP_OFFER, 16'haaaa, 32'd50);
    send_item(OP_OFFER, 16'h0001, 32'd200);
    send_item(OP_OFFER, 16'h0002, 32'd100);
    send_item(OP_OFFER, 16'h0003, 32'd100);
    send_item(OP_OFFER, 16'h0004, 32'd10);
    send_item(OP_DUMP, '0, '0);
    send_item(OP_CLEAR, '1, '1);
    send_item(OP_DUMP, '0, '0);
    drain();

    // k of one
    write_k(6'd1);
    send_item(OP_OFFER, 16'h0010, 32'd7);
    send_item(OP_OFFER, 16'h0011, 32'd7);
    send_item(OP_OFFER, 16'h0012, 32'd3);
    send_item(OP_DUMP, '0, '0);
    drain();

    // k of zero behaves as one
    write_k(6'd0);
    send_item(OP_OFFER, 16'h0020, 32'd9);
    send_item(OP_OFFER, 16'h0021, 32'd3);
    send_item(OP_OFFER, 16'h0022, 32'd1);
    send_item(OP_DUMP, '0, '0);
    send_item(OP_STATUS, ID_W'($urandom), DIST_W'($urandom));

    // random phases over several k settings and idling patterns
    for (int p = 0; p < 6; p++) begin
      drain();
      if (p < 2) begin
        tx_idle_pct = 23;
        rx_idle_pct = 79;
      end else if (p < 4) begin
        tx_idle_pct = 79;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_k(K_W'(k_list[p]));
      run_phase(73, k_list[p]);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### sim.f
src/knnt_pkg.sv
src/knnt_cell.sv
src/knnt_chain.sv
src/k_nearest_with_ties_list_top.sv
verif/knnt_list_checker.sv
verif/tb_k_nearest_with_ties_list_top.sv
